>>> sv/mep_pkg.sv
// Shared types, widths and codes for the Mandelbrot escape-time pixel block.
package mep_pkg;

    // Fixed field widths
    localparam int PIX_W   = 9;
    localparam int PAN_W   = 16;
    localparam int COORD_W = 32;
    localparam int COLOR_W = 32;
    localparam int CNT_O_W = 7;
    localparam int IDX_W   = 3;

    // Mapping arithmetic: offset = pixel + pan, span = hi - lo, product = offset * span
    localparam int OFS_W  = 18;
    localparam int SPAN_W = 33;
    localparam int PROD_W = OFS_W + SPAN_W;
    localparam int MAG_W  = PROD_W - 1;

    // Wide sums ahead of saturation to Q4.28
    localparam int SAT_W  = 52;
    localparam int SQ_W   = 64;
    localparam int FRAC_W = 28;

    // |z|^2 >= 4 in Q.56
    localparam logic [SQ_W-1:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

    // Register reset values
    localparam logic [COORD_W-1:0] RST_WIN_LO = 32'hE000_0000;
    localparam logic [COORD_W-1:0] RST_WIN_HI = 32'h2000_0000;
    localparam logic [COLOR_W-1:0] RST_COLOR  = 32'h0001_0101;

    typedef enum logic [IDX_W-1:0] {
        CFG_WIN_LEFT   = 3'd0,
        CFG_WIN_RIGHT  = 3'd1,
        CFG_WIN_BOTTOM = 3'd2,
        CFG_WIN_TOP    = 3'd3,
        CFG_PAN_H      = 3'd4,
        CFG_PAN_V      = 3'd5,
        CFG_BASE_COLOR = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_MAP_FIN,
        ST_IT_MUL,
        ST_IT_CHK,
        ST_COLOR
    } t_state;

    typedef struct packed {
        logic load_in;
        logic map_mul;
        logic div_start;
        logic map_fin;
        logic it_mul;
        logic it_upd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic iter_stop;
        logic out_free;
    } t_sts;

    // Clamp a wide signed value to the Q4.28 range
    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
        logic [COORD_W-1:0] res;
        if (v[SAT_W-1:COORD_W-1] == {(SAT_W-COORD_W+1){v[SAT_W-1]}}) begin
            res = v[COORD_W-1:0];
        end else if (v[SAT_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

>>> sv/mep_div.sv
// Divider by a fixed constant: multiply by a scaled reciprocal, partial products registered first, then the quotient.
module mep_div #(
    parameter int DIVISOR = 512,
    parameter int NW      = 50
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    output logic [NW-1:0] o_quotient,
    output logic          o_busy
);

    // floor(x / d) == floor(x * REC / 2^SH) for every x below 2^NW,
    // with REC = ceil(2^SH / d) and SH = NW + ceil(log2(d)); REC fits NW + 1 bits
    localparam int          LW  = $clog2(DIVISOR);
    localparam int          SH  = NW + LW;
    localparam logic [63:0] REC = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int          HW  = 32;
    localparam int          XHW = NW - HW;
    localparam int          MHW = NW + 1 - HW;
    localparam int          FW  = 2 * NW + 1;

    localparam logic [HW-1:0]  REC_LO = REC[HW-1:0];
    localparam logic [MHW-1:0] REC_HI = REC[NW:HW];

    logic [HW-1:0]  x_lo;
    logic [XHW-1:0] x_hi;

    logic [2*HW-1:0]      r_pp_ll;
    logic [HW+MHW-1:0]    r_pp_lh;
    logic [XHW+HW-1:0]    r_pp_hl;
    logic [XHW+MHW-1:0]   r_pp_hh;
    logic [NW-1:0]        r_quo;
    logic                 r_busy;

    logic [FW-1:0] full;

    assign x_lo = i_dividend[HW-1:0];
    assign x_hi = i_dividend[NW-1:HW];

    // Partial products first, then one sum and the shift
    assign full = FW'(r_pp_ll)
                + (FW'(r_pp_lh) << HW)
                + (FW'(r_pp_hl) << HW)
                + (FW'(r_pp_hh) << (2 * HW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pp_ll <= (2 * HW)'(x_lo) * (2 * HW)'(REC_LO);
            r_pp_lh <= (HW + MHW)'(x_lo) * (HW + MHW)'(REC_HI);
            r_pp_hl <= (XHW + HW)'(x_hi) * (XHW + HW)'(REC_LO);
            r_pp_hh <= (XHW + MHW)'(x_hi) * (XHW + MHW)'(REC_HI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_quo <= NW'(full >> SH);
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

endmodule

>>> sv/mep_ctrl.sv
// Sequencing state machine: accept, map, divide, iterate, deliver.
module mep_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mep_pkg::t_sts i_sts,
    output mep_pkg::t_cmd o_cmd
);

    mep_pkg::t_state r_state;
    mep_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mep_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            mep_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = mep_pkg::ST_MAP_MUL;
                end
            end
            mep_pkg::ST_MAP_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state       = mep_pkg::ST_DIV_LOAD;
            end
            mep_pkg::ST_DIV_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = mep_pkg::ST_DIV_RUN;
            end
            mep_pkg::ST_DIV_RUN: begin
                if (!i_sts.div_busy) begin
                    n_state = mep_pkg::ST_MAP_FIN;
                end
            end
            mep_pkg::ST_MAP_FIN: begin
                o_cmd.map_fin = 1'b1;
                n_state       = mep_pkg::ST_IT_MUL;
            end
            mep_pkg::ST_IT_MUL: begin
                o_cmd.it_mul = 1'b1;
                n_state      = mep_pkg::ST_IT_CHK;
            end
            mep_pkg::ST_IT_CHK: begin
                if (i_sts.iter_stop) begin
                    n_state = mep_pkg::ST_COLOR;
                end else begin
                    o_cmd.it_upd = 1'b1;
                    n_state      = mep_pkg::ST_IT_MUL;
                end
            end
            mep_pkg::ST_COLOR: begin
                // hold until the output beat is free
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mep_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mep_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/mep_dp.sv
// Datapath: config registers, pixel mapping, z iteration and output register.
module mep_dp #(
    parameter int IMG_WIDTH  = 512,
    parameter int IMG_HEIGHT = 512,
    parameter int ITER_LIMIT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mep_pkg::t_cmd                 i_cmd,
    output mep_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_valid,
    input  logic [mep_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [mep_pkg::COORD_W-1:0]   i_cfg_data,
    input  logic [mep_pkg::PIX_W-1:0]     i_pixel_col,
    input  logic [mep_pkg::PIX_W-1:0]     i_pixel_row,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mep_pkg::PIX_W-1:0]     o_out_col,
    output logic [mep_pkg::PIX_W-1:0]     o_out_row,
    output logic [mep_pkg::CNT_O_W-1:0]   o_iter_count,
    output logic [mep_pkg::COLOR_W-1:0]   o_pixel_color
);

    localparam int CW = $clog2(ITER_LIMIT + 1);

    // Configuration registers
    logic signed [mep_pkg::COORD_W-1:0] r_win_left, r_win_right, r_win_bottom, r_win_top;
    logic signed [mep_pkg::PAN_W-1:0]   r_pan_h, r_pan_v;
    logic [mep_pkg::COLOR_W-1:0]        r_base_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= mep_pkg::RST_WIN_LO;
            r_win_right  <= mep_pkg::RST_WIN_HI;
            r_win_bottom <= mep_pkg::RST_WIN_LO;
            r_win_top    <= mep_pkg::RST_WIN_HI;
            r_pan_h      <= '0;
            r_pan_v      <= '0;
            r_base_color <= mep_pkg::RST_COLOR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mep_pkg::CFG_WIN_LEFT:   r_win_left   <= i_cfg_data;
                mep_pkg::CFG_WIN_RIGHT:  r_win_right  <= i_cfg_data;
                mep_pkg::CFG_WIN_BOTTOM: r_win_bottom <= i_cfg_data;
                mep_pkg::CFG_WIN_TOP:    r_win_top    <= i_cfg_data;
                mep_pkg::CFG_PAN_H:      r_pan_h      <= i_cfg_data[mep_pkg::PAN_W-1:0];
                mep_pkg::CFG_PAN_V:      r_pan_v      <= i_cfg_data[mep_pkg::PAN_W-1:0];
                mep_pkg::CFG_BASE_COLOR: r_base_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pixel capture
    logic [mep_pkg::PIX_W-1:0] r_col, r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col <= i_pixel_col;
            r_row <= i_pixel_row;
        end
    end

    // Mapping: (pixel + pan) * span
    logic signed [mep_pkg::OFS_W-1:0]  ofs_re, ofs_im;
    logic signed [mep_pkg::SPAN_W-1:0] span_re, span_im;
    logic signed [mep_pkg::PROD_W-1:0] prod_re, prod_im;
    logic signed [mep_pkg::PROD_W-1:0] r_prod_re, r_prod_im;

    assign ofs_re  = mep_pkg::OFS_W'($signed({1'b0, r_col})) + mep_pkg::OFS_W'(r_pan_h);
    assign ofs_im  = mep_pkg::OFS_W'($signed({1'b0, r_row})) + mep_pkg::OFS_W'(r_pan_v);
    assign span_re = mep_pkg::SPAN_W'(r_win_right) - mep_pkg::SPAN_W'(r_win_left);
    assign span_im = mep_pkg::SPAN_W'(r_win_top) - mep_pkg::SPAN_W'(r_win_bottom);
    assign prod_re = ofs_re * span_re;
    assign prod_im = ofs_im * span_im;

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_mul) begin
            r_prod_re <= prod_re;
            r_prod_im <= prod_im;
        end
    end

    // Divide magnitudes, reapply sign afterwards (truncation toward zero)
    logic [mep_pkg::PROD_W-1:0] abs_re, abs_im;
    logic [mep_pkg::MAG_W-1:0]  quo_re, quo_im;
    logic                       busy_re, busy_im;

    assign abs_re = r_prod_re[mep_pkg::PROD_W-1] ? -r_prod_re : r_prod_re;
    assign abs_im = r_prod_im[mep_pkg::PROD_W-1] ? -r_prod_im : r_prod_im;

    mep_div #(
        .DIVISOR (IMG_WIDTH),
        .NW      (mep_pkg::MAG_W)
    ) u_div_re (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (abs_re[mep_pkg::MAG_W-1:0]),
        .o_quotient (quo_re),
        .o_busy     (busy_re)
    );

    mep_div #(
        .DIVISOR (IMG_HEIGHT),
        .NW      (mep_pkg::MAG_W)
    ) u_div_im (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (abs_im[mep_pkg::MAG_W-1:0]),
        .o_quotient (quo_im),
        .o_busy     (busy_im)
    );

    logic signed [mep_pkg::SAT_W-1:0] q_re, q_im, c_re_sum, c_im_sum;

    assign q_re = r_prod_re[mep_pkg::PROD_W-1] ? -$signed(mep_pkg::SAT_W'(quo_re))
                                               :  $signed(mep_pkg::SAT_W'(quo_re));
    assign q_im = r_prod_im[mep_pkg::PROD_W-1] ? -$signed(mep_pkg::SAT_W'(quo_im))
                                               :  $signed(mep_pkg::SAT_W'(quo_im));
    assign c_re_sum = mep_pkg::SAT_W'(r_win_left) + q_re;
    assign c_im_sum = mep_pkg::SAT_W'(r_win_bottom) + q_im;

    // Iteration registers
    logic signed [mep_pkg::COORD_W-1:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [mep_pkg::SQ_W-1:0]    r_rr, r_ii, r_ri;
    logic [CW-1:0]                      r_count;

    logic signed [mep_pkg::SQ_W-1:0]  diff;
    logic [mep_pkg::SQ_W-1:0]         mag2;
    logic signed [mep_pkg::SAT_W-1:0] nr, ni;

    assign diff = r_rr - r_ii;
    assign mag2 = unsigned'(r_rr) + unsigned'(r_ii);
    assign nr   = mep_pkg::SAT_W'(diff >>> mep_pkg::FRAC_W) + mep_pkg::SAT_W'(r_cr);
    // factor two of 2*zr*zi folds into the shift
    assign ni   = mep_pkg::SAT_W'(r_ri >>> (mep_pkg::FRAC_W - 1)) + mep_pkg::SAT_W'(r_ci);

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_fin) begin
            r_cr    <= mep_pkg::sat_coord(c_re_sum);
            r_ci    <= mep_pkg::sat_coord(c_im_sum);
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= CW'(1);
        end else if (i_cmd.it_upd) begin
            r_zr    <= mep_pkg::sat_coord(nr);
            r_zi    <= mep_pkg::sat_coord(ni);
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.it_mul) begin
            r_rr <= r_zr * r_zr;
            r_ii <= r_zi * r_zi;
            r_ri <= r_zr * r_zi;
        end
    end

    // Output register
    logic                          r_out_valid;
    logic [mep_pkg::PIX_W-1:0]     r_out_col, r_out_row;
    logic [mep_pkg::CNT_O_W-1:0]   r_out_count;
    logic [mep_pkg::COLOR_W-1:0]   r_out_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_count <= mep_pkg::CNT_O_W'(r_count);
            r_out_color <= (r_count == CW'(ITER_LIMIT)) ? r_base_color
                         : mep_pkg::COLOR_W'(r_base_color * r_count);
        end
    end

    assign o_sts.div_busy  = busy_re | busy_im;
    assign o_sts.iter_stop = (mag2 >= mep_pkg::ESC_LIMIT) || (r_count >= CW'(ITER_LIMIT));
    assign o_sts.out_free  = !r_out_valid || i_ready;

    assign o_valid       = r_out_valid;
    assign o_out_col     = r_out_col;
    assign o_out_row     = r_out_row;
    assign o_iter_count  = r_out_count;
    assign o_pixel_color = r_out_color;

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy_re == busy_im)
        else $error("divider lanes out of step");

    a_upd_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.it_upd |-> (r_count < CW'(ITER_LIMIT)))
        else $error("iteration advanced at the limit");

    a_load_shows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !i_cmd.out_load)
        else $error("pending result overwritten");

endmodule

>>> sv/mandelbrot_escape_pixel.sv
// Top level of the Mandelbrot escape-time pixel evaluator.
// One pixel at a time: an accepted (column, row) beat is mapped into the
// configured complex window, then z = z*z + c is iterated until |z|^2 >= 4 or
// the count reaches ITER_LIMIT. With the output free, each item goes through
// these steps in order, N being the reported iteration count: the accepting
// cycle, the mapping multiply, the start of the divide, the reciprocal-multiply
// divide by the image size (both axes in parallel), finishing c, then N
// iterations of squares registered followed by escape test and update, and
// forming the color, which loads the output register and raises o_valid. A
// finished result waits in the output register while the next pixel is
// accepted and worked on; the color step holds while that register is still
// occupied and not taken. Configuration writes are taken in any cycle and
// must only be issued while no pixel is in flight.
module mandelbrot_escape_pixel #(
    parameter int IMG_WIDTH  = 512,
    parameter int IMG_HEIGHT = 512,
    parameter int ITER_LIMIT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mep_pkg::PIX_W-1:0]     i_pixel_col,
    input  logic [mep_pkg::PIX_W-1:0]     i_pixel_row,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mep_pkg::PIX_W-1:0]     o_out_col,
    output logic [mep_pkg::PIX_W-1:0]     o_out_row,
    output logic [mep_pkg::CNT_O_W-1:0]   o_iter_count,
    output logic [mep_pkg::COLOR_W-1:0]   o_pixel_color,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mep_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [mep_pkg::COORD_W-1:0]   i_cfg_data
);

    mep_pkg::t_cmd cmd;
    mep_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    mep_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mep_dp #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .ITER_LIMIT (ITER_LIMIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_col   (i_pixel_col),
        .i_pixel_row   (i_pixel_row),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row),
        .o_iter_count  (o_iter_count),
        .o_pixel_color (o_pixel_color)
    );

endmodule
